/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LZ_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define LZ_ASSERT_NEVER(name, clk, rstn, cond) \
  `LZ_ASSERT(name, clk, rstn, !(cond))
`else
`define LZ_ASSERT(name, clk, rstn, prop)
`define LZ_ASSERT_NEVER(name, clk, rstn, cond)
`endif
`endif

/* design/lztd_pkg.sv */
// ----------------------------------------------------------------------------
// LZ77 token decompressor package
// Shared types, codes and default parameters.
// ----------------------------------------------------------------------------
package lztd_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 4096;
  localparam int unsigned MAX_COPY_LEN_DEF  = 512;
  localparam int unsigned LANES_DEF         = 8;

  localparam logic [7:0]  LIT_LIMIT = 8'h80;
  localparam logic [7:0]  ESC_BYTE  = 8'hFF;
  localparam logic [16:0] BYTES_SAT = 17'h10000;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TRUNC    = 3'd1,
    ST_BAD_DIST = 3'd2,
    ST_ZERO_LEN = 3'd3,
    ST_TOO_LONG = 3'd4,
    ST_DROP     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CMD_LIT  = 2'd0,
    CMD_COPY = 2'd1,
    CMD_STAT = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_last;
  } in_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        run_last;
    logic        stream_end;
    status_e     status;
  } out_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic [15:0] len;
    logic [15:0] ref_dist;
    status_e     status;
    logic        last;
  } cmd_t;

endpackage

/* design/lz77_token_decompressor_unit.sv */
// ----------------------------------------------------------------------------
// LZ77 token decompressor
// Input side takes one compressed byte per transfer (push/full); output side
// offers results (empty/pop), each carrying up to LANES decoded bytes with
// count, run_last, stream_end and status.
// A parser classifies bytes and checks references, a two-entry command queue
// decouples it from the copy engine, which reads and writes the history RAM.
// A literal passes from the command queue through the engine's idle and
// output states into the output register. A copy reads and then writes
// the history RAM port pair for each byte and takes an output step per
// result. A literal holds the engine in its idle and output states, and
// the engine takes no new command before it is back in idle.
// The output register lets the engine hand over a result while the previous
// one is popped; when pop stays low the engine and then the queue stall and
// full rises. Reset clears parser, queue and engine state and the write
// pointer; the history RAM is not cleared and is only read where written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lz77_token_decompressor_unit
  import lztd_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int unsigned MAX_COPY_LEN  = MAX_COPY_LEN_DEF,
  parameter int unsigned LANES         = LANES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  input  in_t  in_data_i,
  output logic full,
  output logic empty,
  input  logic pop,
  output out_t out_data_o
);

  localparam logic [3:0] LanesW = 4'(LANES);

  logic in_ready;
  logic fq_wr_valid, fq_wr_ready;
  cmd_t fq_wr_data;
  logic fq_rd_valid, fq_rd_ready;
  cmd_t fq_rd_data;
  logic out_valid;

  lztd_front #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .MAX_COPY_LEN (MAX_COPY_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (push),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready),
    .cmd_valid_o(fq_wr_valid),
    .cmd_o      (fq_wr_data),
    .cmd_ready_i(fq_wr_ready)
  );

  lztd_cmd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fq_wr_valid),
    .wr_data_i (fq_wr_data),
    .wr_ready_o(fq_wr_ready),
    .rd_valid_o(fq_rd_valid),
    .rd_data_o (fq_rd_data),
    .rd_ready_i(fq_rd_ready)
  );

  lztd_back #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .LANES        (LANES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(fq_rd_valid),
    .cmd_i      (fq_rd_data),
    .cmd_ready_o(fq_rd_ready),
    .out_valid_o(out_valid),
    .out_o      (out_data_o),
    .out_ready_i(pop)
  );

  assign full  = !in_ready;
  assign empty = !out_valid;

  `LZ_ASSERT(a_count_bound, clk_i, rst_ni, !empty |-> out_data_o.byte_count <= LanesW)
  `LZ_ASSERT(a_end_is_run_last, clk_i, rst_ni, (!empty && out_data_o.stream_end) |-> out_data_o.run_last)
  `LZ_ASSERT_NEVER(a_empty_ok, clk_i, rst_ni, !empty && out_data_o.byte_count == 4'd0 && out_data_o.status == ST_OK && !out_data_o.stream_end)
  `LZ_ASSERT_NEVER(a_data_with_error, clk_i, rst_ni, !empty && out_data_o.byte_count != 4'd0 && out_data_o.status != ST_OK)

endmodule

/* design/lztd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lztd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/lztd_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue between the token parser and the copy engine.
// ----------------------------------------------------------------------------
module lztd_cmd_fifo
  import lztd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  input  cmd_t wr_data_i,
  output logic wr_ready_o,
  output logic rd_valid_o,
  output cmd_t rd_data_o,
  input  logic rd_ready_i
);

  cmd_t       mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_wr, do_rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_comb begin
    wptr_d = do_wr ? ~wptr_q : wptr_q;
    rptr_d = do_rd ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

/* design/lztd_front.sv */
// ----------------------------------------------------------------------------
// Token parser
// Takes compressed bytes, checks references and issues one command per byte
// that leads to a result.
// ----------------------------------------------------------------------------
module lztd_front
  import lztd_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int unsigned MAX_COPY_LEN  = MAX_COPY_LEN_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  in_t  in_data_i,
  output logic in_ready_o,
  output logic cmd_valid_o,
  output cmd_t cmd_o,
  input  logic cmd_ready_i
);

  typedef enum logic [6:0] {
    PH_TOKEN = 7'b0000001,
    PH_ESC   = 7'b0000010,
    PH_LEN   = 7'b0000100,
    PH_LENLO = 7'b0001000,
    PH_LENHI = 7'b0010000,
    PH_DLO   = 7'b0100000,
    PH_DHI   = 7'b1000000
  } phase_e;

  localparam logic [16:0] DepthLim = 17'(HISTORY_DEPTH);
  localparam logic [15:0] LenLim   = 16'(MAX_COPY_LEN);

  phase_e      ph_q, ph_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  dlo_q, dlo_d;
  logic [16:0] bp_q, bp_d;
  logic        err_q, err_d;
  logic        acc, emit;
  logic [7:0]  b;
  logic [15:0] ref_dist;
  logic [17:0] bp_sum;
  cmd_t        cmd;

  assign in_ready_o  = cmd_ready_i;
  assign acc         = in_valid_i && cmd_ready_i;
  assign b           = in_data_i.in_byte;
  assign ref_dist    = {b, dlo_q};
  assign bp_sum      = {1'b0, bp_q} + {2'b00, len_q};
  assign cmd_valid_o = acc && emit;
  assign cmd_o       = cmd;

  always_comb begin
    ph_d         = ph_q;
    len_d        = len_q;
    dlo_d        = dlo_q;
    bp_d         = bp_q;
    err_d        = err_q;
    emit         = 1'b0;
    cmd          = '0;
    cmd.kind     = CMD_LIT;
    cmd.data     = b;
    cmd.len      = len_q;
    cmd.ref_dist = ref_dist;
    cmd.status   = ST_OK;
    if (err_q) begin
      if (in_data_i.stream_last) begin
        emit       = 1'b1;
        cmd.kind   = CMD_STAT;
        cmd.status = ST_DROP;
      end
    end else begin
      unique case (ph_q)
        PH_TOKEN: begin
          if (b < LIT_LIMIT) begin
            emit = 1'b1;
            if (bp_q != BYTES_SAT) bp_d = bp_q + 17'd1;
          end else if (b == ESC_BYTE) begin
            ph_d = PH_ESC;
          end else begin
            ph_d = PH_LEN;
          end
        end
        PH_ESC: begin
          emit = 1'b1;
          if (bp_q != BYTES_SAT) bp_d = bp_q + 17'd1;
          ph_d = PH_TOKEN;
        end
        PH_LEN: begin
          if (b == ESC_BYTE) begin
            ph_d = PH_LENLO;
          end else begin
            len_d = {8'h00, b};
            ph_d  = PH_DLO;
          end
        end
        PH_LENLO: begin
          len_d = {8'h00, b};
          ph_d  = PH_LENHI;
        end
        PH_LENHI: begin
          len_d = {b, len_q[7:0]};
          ph_d  = PH_DLO;
        end
        PH_DLO: begin
          dlo_d = b;
          ph_d  = PH_DHI;
        end
        PH_DHI: begin
          ph_d = PH_TOKEN;
          emit = 1'b1;
          if (ref_dist == 16'd0 || {1'b0, ref_dist} > bp_q ||
              {1'b0, ref_dist} > DepthLim) begin
            cmd.kind   = CMD_STAT;
            cmd.status = ST_BAD_DIST;
          end else if (len_q == 16'd0) begin
            cmd.kind   = CMD_STAT;
            cmd.status = ST_ZERO_LEN;
          end else if (len_q > LenLim) begin
            cmd.kind   = CMD_STAT;
            cmd.status = ST_TOO_LONG;
          end else begin
            cmd.kind = CMD_COPY;
            bp_d     = (bp_sum > {1'b0, BYTES_SAT}) ? BYTES_SAT : bp_sum[16:0];
          end
          if (cmd.kind == CMD_STAT) err_d = 1'b1;
        end
        default: begin
          ph_d = PH_TOKEN;
        end
      endcase
      if (in_data_i.stream_last && !emit) begin
        emit       = 1'b1;
        cmd.kind   = CMD_STAT;
        cmd.status = (ph_d != PH_TOKEN) ? ST_TRUNC : ST_OK;
      end
    end
    if (in_data_i.stream_last) begin
      cmd.last = 1'b1;
      ph_d     = PH_TOKEN;
      len_d    = 16'd0;
      dlo_d    = 8'd0;
      bp_d     = 17'd0;
      err_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_TOKEN;
      len_q <= 16'd0;
      dlo_q <= 8'd0;
      bp_q  <= 17'd0;
      err_q <= 1'b0;
    end else if (acc) begin
      ph_q  <= ph_d;
      len_q <= len_d;
      dlo_q <= dlo_d;
      bp_q  <= bp_d;
      err_q <= err_d;
    end
  end

endmodule

/* design/lztd_back.sv */
// ----------------------------------------------------------------------------
// Copy engine
// Carries out commands against the history memory and packs decoded bytes
// into results held in an output register.
// ----------------------------------------------------------------------------
module lztd_back
  import lztd_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int unsigned LANES         = LANES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_ready_o,
  output logic out_valid_o,
  output out_t out_o,
  input  logic out_ready_i
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0] PtrMax   = AW'(HISTORY_DEPTH - 1);
  localparam logic [16:0]   DepthW   = 17'(HISTORY_DEPTH);
  localparam logic [3:0]    LanesW   = 4'(LANES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_WR   = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e        st_q, st_d;
  cmd_t          cmd_q, cmd_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [AW-1:0] rp_q, rp_d;
  logic [15:0]   rem_q, rem_d;
  logic [63:0]   word_q, word_d;
  logic [3:0]    cnt_q, cnt_d;
  logic [6:0]    chunk_q, chunk_d;
  logic          final_q, final_d;
  logic          ovalid_q, ovalid_d;
  out_t          out_q, out_d;
  logic          we;
  logic [7:0]    wdata;
  logic [7:0]    rdata;
  logic          slot_free;
  logic          run_last;
  logic [16:0]   wpx, distx;

  function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
    return (p == PtrMax) ? '0 : p + AW'(1);
  endfunction

  lztd_ram #(
    .WIDTH(8),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wp_q),
    .wdata_i(wdata),
    .raddr_i(rp_q),
    .rdata_o(rdata)
  );

  assign cmd_ready_o = (st_q == S_IDLE);
  assign slot_free   = !ovalid_q || out_ready_i;
  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;
  assign wpx         = 17'(wp_q);
  assign distx       = {1'b0, cmd_i.ref_dist};
  assign run_last    = final_q || (chunk_q == 7'd63);

  always_comb begin
    st_d     = st_q;
    cmd_d    = cmd_q;
    wp_d     = wp_q;
    rp_d     = rp_q;
    rem_d    = rem_q;
    word_d   = word_q;
    cnt_d    = cnt_q;
    chunk_d  = chunk_q;
    final_d  = final_q;
    ovalid_d = ovalid_q && !out_ready_i;
    out_d    = out_q;
    we       = 1'b0;
    wdata    = rdata;
    unique case (st_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          word_d  = '0;
          cnt_d   = 4'd0;
          chunk_d = 7'd0;
          final_d = 1'b1;
          unique case (cmd_i.kind)
            CMD_LIT: begin
              we     = 1'b1;
              wdata  = cmd_i.data;
              wp_d   = ptr_inc(wp_q);
              word_d = {56'd0, cmd_i.data};
              cnt_d  = 4'd1;
              st_d   = S_OUT;
            end
            CMD_COPY: begin
              rp_d    = (wpx >= distx) ? AW'(wpx - distx) : AW'(wpx + DepthW - distx);
              rem_d   = cmd_i.len;
              final_d = 1'b0;
              st_d    = S_RD;
            end
            default: begin
              st_d = S_OUT;
            end
          endcase
        end
      end
      S_RD: begin
        st_d = S_WR;
      end
      S_WR: begin
        we                   = 1'b1;
        wdata                = rdata;
        wp_d                 = ptr_inc(wp_q);
        rp_d                 = ptr_inc(rp_q);
        word_d[cnt_q[2:0]*8 +: 8] = rdata;
        cnt_d                = cnt_q + 4'd1;
        rem_d                = rem_q - 16'd1;
        if (rem_q == 16'd1) begin
          final_d = 1'b1;
          st_d    = S_OUT;
        end else if (cnt_q + 4'd1 == LanesW) begin
          st_d = S_OUT;
        end else begin
          st_d = S_RD;
        end
      end
      S_OUT: begin
        if (chunk_q[6] || slot_free) begin
          if (!chunk_q[6]) begin
            ovalid_d         = 1'b1;
            out_d.out_bytes  = word_q;
            out_d.byte_count = cnt_q;
            out_d.status     = cmd_q.status;
            out_d.run_last   = run_last;
            out_d.stream_end = cmd_q.last && run_last;
            chunk_d          = chunk_q + 7'd1;
          end
          word_d = '0;
          cnt_d  = 4'd0;
          st_d   = final_q ? S_IDLE : S_RD;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      wp_q     <= '0;
      ovalid_q <= 1'b0;
      chunk_q  <= 7'd0;
      final_q  <= 1'b0;
      rem_q    <= 16'd0;
      cnt_q    <= 4'd0;
    end else begin
      st_q     <= st_d;
      wp_q     <= wp_d;
      ovalid_q <= ovalid_d;
      chunk_q  <= chunk_d;
      final_q  <= final_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    rp_q   <= rp_d;
    word_q <= word_d;
    out_q  <= out_d;
  end

endmodule
